### rtl/assert_macros.svh
// Assertion macros shared by the RTL files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/ttt_pkg.sv
// Package: constants, types and helpers for the thermistor temperature tracker
package ttt_pkg;

  localparam int AdcBits = 12;
  localparam logic [11:0] CodeTop = 12'((1 << AdcBits) - 1);

  localparam logic [29:0] Ln2Q30 = 30'd744261118;
  // Steinhart-Hart coefficients, Q56
  localparam logic [63:0] ShAQ56 =
    ((((64'd1129148 << 40) / 64'd1953125) << 7) +
     ((((64'd1129148 << 40) % 64'd1953125) << 7) / 64'd1953125));
  localparam logic [63:0] ShBQ56 =
    ((((64'd234125 << 40) / 64'd1953125) << 7) +
     ((((64'd234125 << 40) % 64'd1953125) << 7) / 64'd1953125));
  localparam logic [63:0] ShCQ56 =
    ((((64'd876741 << 40) / 64'd1220703125) << 3) +
     ((((64'd876741 << 40) % 64'd1220703125) << 3) / 64'd1220703125));

  // ceil(2^22 / 5), exact floor divide by 5 below 2^20
  localparam logic [19:0] FahrRecip = 20'd838861;

  localparam logic signed [16:0] CelsiusMin = -17'sd15000;
  localparam logic signed [16:0] CelsiusMax = 17'sd50000;
  localparam logic signed [16:0] LastReset = -17'sd10000;

  localparam logic [1:0] CfgSeries = 2'd0;
  localparam logic [1:0] CfgOffset = 2'd1;
  localparam logic [1:0] CfgThresh = 2'd2;

  // Datapath operations
  localparam logic [3:0] OpNone   = 4'd0;
  localparam logic [3:0] OpLnLoad = 4'd1;
  localparam logic [3:0] OpLnSq   = 4'd2;
  localparam logic [3:0] OpLnEnd  = 4'd3;
  localparam logic [3:0] OpMulLd  = 4'd4;
  localparam logic [3:0] OpMulHH  = 4'd5;
  localparam logic [3:0] OpMulHL  = 4'd6;
  localparam logic [3:0] OpMulLH  = 4'd7;
  localparam logic [3:0] OpMulLo  = 4'd8;
  localparam logic [3:0] OpDivLd  = 4'd9;
  localparam logic [3:0] OpDivStp = 4'd10;
  localparam logic [3:0] OpFinish = 4'd11;

  typedef struct packed {
    logic [3:0] op;
    logic [1:0] sel;
  } ttt_cmd_t;

  typedef struct packed {
    logic d_pos;
  } ttt_sts_t;

endpackage

### rtl/ttt_datapath.sv
// Datapath: log, multiply, divide and output formatting registers
`include "assert_macros.svh"
module ttt_datapath
  import ttt_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  ttt_cmd_t            cmd,
  output ttt_sts_t            sts,
  input  logic [11:0]         code,
  input  logic [19:0]         series,
  input  logic signed [10:0]  offset,
  input  logic [9:0]          thresh,
  input  logic                conn,
  output logic signed [16:0]  celsius,
  output logic signed [17:0]  fahrenheit,
  output logic                moved
);

  // log unit
  logic [31:0] ln_mant;
  logic [4:0]  ln_exp;
  logic [27:0] ln_frac;
  logic [31:0] ln_arg;
  logic [4:0]  ln_e;
  logic [63:0] sq;
  logic [32:0] sq_s;
  logic [32:0] l2v;
  logic [64:0] lnp;
  logic signed [37:0] ln_val;
  logic signed [37:0] lnr;

  // multiplier
  logic signed [65:0] mc;
  logic signed [65:0] mx;
  logic signed [65:0] macc;
  logic signed [65:0] mhi;
  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [65:0] mprod;
  logic signed [65:0] mpart;
  logic signed [65:0] l2q;
  logic signed [65:0] l3q;
  logic signed [65:0] dacc;

  // divider
  logic [63:0] dvs;
  logic [63:0] rem;
  logic [63:0] quo;
  logic [64:0] rem_sh;

  logic signed [16:0] last;
  logic               kelvin_big;
  logic signed [31:0] c_raw;
  logic signed [16:0] c_sat;
  logic signed [21:0] f_num;
  logic [41:0]        f_prod;
  logic signed [17:0] diff_abs;
  logic signed [17:0] diff;

  always_comb begin
    case (cmd.sel)
      2'd0: ln_arg = {12'd0, (series == 20'd0) ? 20'd1 : series};
      2'd1: ln_arg = {20'd0, code};
      default: ln_arg = {20'd0, CodeTop - code};
    endcase
    ln_e = 5'd0;
    for (int i = 1; i < 31; i++) begin
      if (ln_arg[i]) ln_e = 5'(i);
    end
  end

  assign sq   = ln_mant * ln_mant;
  assign sq_s = sq[62:30];
  assign l2v  = {ln_exp, ln_frac};
  assign lnp  = 65'(l2v) * 65'(Ln2Q30) + (65'd1 << 29);
  assign ln_val = 38'(lnp >> 30);

  // c * x as c * (x >>> 16) and c * x[15:0], c split into 32-bit halves,
  // one 33 x 33 partial product per cycle
  assign mul_a = (cmd.op inside {OpMulHH, OpMulLH}) ? $signed(mc[64:32])
                                                    : $signed({1'b0, mc[31:0]});
  assign mul_b = (cmd.op inside {OpMulHH, OpMulHL}) ? $signed(mx[48:16])
                                                    : $signed({17'd0, mx[15:0]});
  assign mprod = mul_a * mul_b;
  assign macc = mhi + ((mpart + mprod) >>> 28);

  assign rem_sh = {rem, quo[63]};

  always_ff @(posedge clk) begin
    case (cmd.op)
      OpLnLoad: begin
        ln_mant <= 32'({ln_arg == 32'd0 ? 32'd1 : ln_arg} << (5'd30 - ln_e));
        ln_exp <= ln_e;
        ln_frac <= '0;
      end
      OpLnSq: begin
        if (sq_s[31]) begin
          ln_mant <= 32'(sq_s >> 1);
          ln_frac <= {ln_frac[26:0], 1'b1};
        end else begin
          ln_mant <= sq_s[31:0];
          ln_frac <= {ln_frac[26:0], 1'b0};
        end
      end
      OpLnEnd: begin
        if (cmd.sel == 2'd0) lnr <= ln_val;
        else if (cmd.sel == 2'd1) lnr <= lnr + ln_val;
        else lnr <= lnr - ln_val;
      end
      OpMulLd: begin
        case (cmd.sel)
          2'd0: begin mc <= 66'(lnr); mx <= 66'(lnr); end
          2'd1: begin mc <= l2q; mx <= 66'(lnr); end
          2'd2: begin mc <= $signed({2'b0, ShBQ56}); mx <= 66'(lnr);
            dacc <= $signed({2'b0, ShAQ56}); end
          default: begin mc <= $signed({2'b0, ShCQ56}); mx <= l3q; end
        endcase
      end
      OpMulHH: mpart <= $signed({mprod[33:0], 32'd0});
      OpMulHL: mhi <= (mpart + mprod) >>> 12;
      OpMulLH: mpart <= $signed({mprod[33:0], 32'd0});
      OpMulLo: begin
        case (cmd.sel)
          2'd0: l2q <= macc;
          2'd1: l3q <= macc;
          default: dacc <= dacc + macc;
        endcase
      end
      OpDivLd: begin
        dvs <= dacc[63:0];
        quo <= (64'd100 << 56) + (dacc[63:0] >> 1);
        rem <= '0;
      end
      OpDivStp: begin
        if (rem_sh >= {1'b0, dvs}) begin
          rem <= 64'(rem_sh - {1'b0, dvs});
          quo <= {quo[62:0], 1'b1};
        end else begin
          rem <= rem_sh[63:0];
          quo <= {quo[62:0], 1'b0};
        end
      end
      default: ;
    endcase
  end

  assign sts.d_pos = !dacc[65] && (dacc != 66'sd0);

  always_comb begin
    kelvin_big = !sts.d_pos || (quo[63:20] != 44'd0);
    c_raw = $signed({12'd0, quo[19:0]}) - 32'sd27315 + 32'(offset);
    if (kelvin_big || c_raw > 32'(CelsiusMax)) c_sat = CelsiusMax;
    else if (c_raw < 32'(CelsiusMin)) c_sat = CelsiusMin;
    else c_sat = c_raw[16:0];
    f_num = 22'(c_sat) * 22'sd9 + 22'sd16002 + 22'sd500000;
    f_prod = 42'(f_num[19:0]) * 42'(FahrRecip);
    diff = 18'(c_sat) - 18'(last);
    diff_abs = diff[17] ? -diff : diff;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last <= LastReset;
    end else if (cmd.op == OpFinish) begin
      if (conn) begin
        celsius <= c_sat;
        fahrenheit <= 18'($signed({2'b00, f_prod[41:22]}) - 22'sd100000);
        moved <= (18'(diff_abs) >= {8'd0, thresh});
        if (18'(diff_abs) >= {8'd0, thresh}) last <= c_sat;
      end else begin
        celsius <= '0;
        fahrenheit <= '0;
        moved <= 1'b0;
      end
    end
  end

  `ASSERT_IMPLY(a_ln_frac_range, clk, rst, cmd.op == OpLnLoad, ln_e <= 5'd30,
    "log exponent out of range")

endmodule

### rtl/ttt_control.sv
// Controller: sequences log, multiply and divide steps for one request
`include "assert_macros.svh"
module ttt_control
  import ttt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic       conn,
  input  ttt_sts_t   sts,
  output ttt_cmd_t   cmd,
  output logic       busy,
  output logic       done
);

  localparam logic [3:0] SIdle  = 4'd0;
  localparam logic [3:0] SLnLd  = 4'd1;
  localparam logic [3:0] SLnSq  = 4'd2;
  localparam logic [3:0] SLnEnd = 4'd3;
  localparam logic [3:0] SMLd   = 4'd4;
  localparam logic [3:0] SMHH   = 4'd5;
  localparam logic [3:0] SMHL   = 4'd6;
  localparam logic [3:0] SMLH   = 4'd7;
  localparam logic [3:0] SMLo   = 4'd8;
  localparam logic [3:0] SDivLd = 4'd9;
  localparam logic [3:0] SDiv   = 4'd10;
  localparam logic [3:0] SFin   = 4'd11;

  logic [3:0] state, state_next;
  logic [5:0] cnt, cnt_next;
  logic [1:0] sel, sel_next;

  assign busy = (state != SIdle);
  assign done = (state == SFin);

  always_comb begin
    state_next = state;
    cnt_next = cnt;
    sel_next = sel;
    cmd.op = OpNone;
    cmd.sel = sel;
    case (state)
      SIdle: if (start) begin
        state_next = conn ? SLnLd : SFin;
        sel_next = 2'd0;
      end
      SLnLd: begin
        cmd.op = OpLnLoad; cnt_next = 6'd0; state_next = SLnSq;
      end
      SLnSq: begin
        cmd.op = OpLnSq; cnt_next = cnt + 6'd1;
        if (cnt == 6'd27) state_next = SLnEnd;
      end
      SLnEnd: begin
        cmd.op = OpLnEnd;
        if (sel == 2'd2) begin sel_next = 2'd0; state_next = SMLd; end
        else begin sel_next = sel + 2'd1; state_next = SLnLd; end
      end
      SMLd: begin cmd.op = OpMulLd; state_next = SMHH; end
      SMHH: begin cmd.op = OpMulHH; state_next = SMHL; end
      SMHL: begin cmd.op = OpMulHL; state_next = SMLH; end
      SMLH: begin cmd.op = OpMulLH; state_next = SMLo; end
      SMLo: begin
        cmd.op = OpMulLo;
        if (sel == 2'd3) state_next = SDivLd;
        else begin sel_next = sel + 2'd1; state_next = SMLd; end
      end
      SDivLd: begin
        cmd.op = OpDivLd; cnt_next = 6'd0;
        state_next = sts.d_pos ? SDiv : SFin;
      end
      SDiv: begin
        cmd.op = OpDivStp; cnt_next = cnt + 6'd1;
        if (cnt == 6'd63) state_next = SFin;
      end
      SFin: begin cmd.op = OpFinish; state_next = SIdle; end
      default: state_next = SIdle;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SIdle;
      cnt <= '0;
      sel <= '0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
      sel <= sel_next;
    end
  end

  `ASSERT_NEXT(a_start_busy, clk, rst, start && !busy, busy,
    "request accepted but controller stayed idle")
  `ASSERT_IMPLY(a_div_count, clk, rst, state == SDiv, cnt <= 6'd63,
    "divide counter overran")

endmodule

### rtl/thermistor_temperature_tracker_top.sv
// Top level: thermistor temperature tracker with request and result channels
// A connected sample runs three 28-step logarithms, four split multiplications and
// a 64-step restoring divider from acceptance to result; a non-positive
// Steinhart-Hart denominator skips the divider. A disconnected sample goes
// straight to the finish step. One sample is in work at a time; a result waits
// in the output register and the next sample is taken in the cycle after it has
// been delivered.
`include "assert_macros.svh"
module thermistor_temperature_tracker_top
  import ttt_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [19:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [11:0]         adc_sample,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                connected,
  output logic                connection_changed,
  output logic signed [16:0]  temp_celsius,
  output logic signed [17:0]  temp_fahrenheit,
  output logic                reading_changed
);

  logic [19:0] series;
  logic signed [10:0] offset;
  logic [9:0] thresh;
  logic [11:0] code;
  logic conn, was_conn, in_conn;
  logic busy, done, start;
  ttt_cmd_t cmd;
  ttt_sts_t sts;

  assign in_ready = !busy && !out_valid;
  assign start = in_valid && in_ready;
  assign in_conn = !(adc_sample <= 12'd1 || adc_sample >= CodeTop - 12'd1);
  assign connected = conn;

  always_ff @(posedge clk) begin
    if (rst) begin
      series <= 20'd10000;
      offset <= -11'sd80;
      thresh <= 10'd10;
    end else if (cfg_we) begin
      case (cfg_index)
        CfgSeries: series <= cfg_data;
        CfgOffset: offset <= cfg_data[10:0];
        CfgThresh: thresh <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      was_conn <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      if (start) begin
        code <= adc_sample;
        conn <= in_conn;
        connection_changed <= (in_conn != was_conn);
        was_conn <= in_conn;
      end
      if (done) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  ttt_control u_ctrl (
    .clk(clk), .rst(rst), .start(start), .conn(in_conn), .sts(sts),
    .cmd(cmd), .busy(busy), .done(done)
  );

  ttt_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts), .code(code), .series(series),
    .offset(offset), .thresh(thresh), .conn(conn), .celsius(temp_celsius),
    .fahrenheit(temp_fahrenheit), .moved(reading_changed)
  );

  `ASSERT_IMPLY(a_no_overlap, clk, rst, out_valid, !busy,
    "work in progress while result pending")
  `ASSERT_IMPLY(a_disc_zero, clk, rst, out_valid && !connected,
    temp_celsius == 17'sd0 && !reading_changed, "disconnected result not zero")

endmodule
